[rtl/core/o2g_pkg.sv]
// ----------------------------------------------------------------------------
// o2g_pkg: shared constants and types
// Field widths, fixed-point formats and register indexes for the
// orientation-from-two-vectors block.
// ----------------------------------------------------------------------------
package o2g_pkg;

  localparam int unsigned GW           = 24;         // input component, Q3.20
  localparam int unsigned VW           = 2 * GW + 1; // cross product component
  localparam int unsigned NW           = 31;         // normalised magnitude
  localparam int unsigned RW           = NW + 1;     // root and divider remainder
  localparam int unsigned UW           = 32;         // unit component, Q1.30 signed
  localparam int unsigned U2W          = UW + 1;     // rebuilt middle row
  localparam int unsigned BTW          = 21;         // BT element, Q8.12
  localparam int unsigned BTRW         = 3 * BTW;    // packed BT row
  localparam int unsigned MW           = 32;         // result element, Q11.20
  localparam int unsigned SQ_STEPS     = RW;         // root bits
  localparam int unsigned DV_STEPS     = NW;         // quotient bits
  localparam int unsigned STEP_PER_DEF = 2;
  localparam int unsigned CIW          = 2;

  typedef enum logic [CIW-1:0] {
    CFG_BT_ROW0 = 2'd0,
    CFG_BT_ROW1 = 2'd1,
    CFG_BT_ROW2 = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic zero;
  } unit_st_t;

endpackage

[rtl/core/orientation_from_two_gvectors.sv]
// ----------------------------------------------------------------------------
// orientation_from_two_gvectors: two-reflection orientation matrix
// Builds the orthonormal triad from g1 and g1 x g2 and returns BT * U in
// Q11.20, with a degenerate flag for zero or parallel vectors.
//
//   channel | ports                              | direction
//   --------+------------------------------------+----------
//   in      | in_valid/in_ready, in_g1_*, in_g2_* | beat in
//   out     | out_valid/out_ready, out_m*, out_degenerate | beat out
//   cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data    | write
//
// One beat per cycle while the pipe is not stalled. STEP_PER sets how many
// root or quotient bits each square-root and divider stage resolves.
// A single stage enable moves the pipe; it stalls only when the output
// register is full, not taken, and the last stage holds a beat.
// Reset clears valid bits and BT; cfg is always ready.
// ----------------------------------------------------------------------------
module orientation_from_two_gvectors #(
  parameter int unsigned STEP_PER = o2g_pkg::STEP_PER_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [o2g_pkg::GW-1:0]  in_g1_x,
  input  logic signed [o2g_pkg::GW-1:0]  in_g1_y,
  input  logic signed [o2g_pkg::GW-1:0]  in_g1_z,
  input  logic signed [o2g_pkg::GW-1:0]  in_g2_x,
  input  logic signed [o2g_pkg::GW-1:0]  in_g2_y,
  input  logic signed [o2g_pkg::GW-1:0]  in_g2_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [o2g_pkg::MW-1:0]  out_m00,
  output logic signed [o2g_pkg::MW-1:0]  out_m01,
  output logic signed [o2g_pkg::MW-1:0]  out_m02,
  output logic signed [o2g_pkg::MW-1:0]  out_m10,
  output logic signed [o2g_pkg::MW-1:0]  out_m11,
  output logic signed [o2g_pkg::MW-1:0]  out_m12,
  output logic signed [o2g_pkg::MW-1:0]  out_m20,
  output logic signed [o2g_pkg::MW-1:0]  out_m21,
  output logic signed [o2g_pkg::MW-1:0]  out_m22,
  output logic                           out_degenerate,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [o2g_pkg::CIW-1:0]        cfg_index,
  input  logic [o2g_pkg::BTRW-1:0]       cfg_data
);
  import o2g_pkg::*;

  localparam int unsigned PRW = 2 * UW;
  localparam int unsigned BPW = BTW + U2W;
  localparam int unsigned AW  = BPW + 2;

  function automatic logic signed [63:0] rnd_haz(input logic signed [63:0] x,
                                                 input int unsigned n);
    logic [63:0] a;
    a = x[63] ? 64'(-x) : 64'(x);
    a = (a + (64'd1 << (n - 1))) >> n;
    return x[63] ? -$signed(a) : $signed(a);
  endfunction

  logic                  en;
  logic [BTRW-1:0]       bt_r [3];

  logic                  c1_v_r;
  logic signed [2*GW-1:0] cp_r [6];
  logic signed [GW-1:0]  g1_c1_r [3];
  logic                  c2_v_r;
  logic signed [VW-1:0]  c_r [3];
  logic signed [VW-1:0]  g1_c2_r [3];

  logic signed [UW-1:0]  u_g [3];
  logic signed [UW-1:0]  u_c [3];
  unit_st_t              g_st;
  unit_st_t              c_st;

  logic                  t1_v_r;
  logic signed [PRW-1:0] up_r [6];
  logic signed [UW-1:0]  u1_t1_r [3];
  logic signed [UW-1:0]  u3_t1_r [3];
  logic                  deg_t1_r;

  logic signed [U2W-1:0] u2_nxt [3];
  logic                  t2_v_r;
  logic signed [U2W-1:0] ut_r [3][3];
  logic                  deg_t2_r;

  logic                  t3_v_r;
  logic signed [BPW-1:0] bp_r [3][3][3];
  logic                  deg_t3_r;

  logic [MW-1:0]         om_nxt [3][3];
  logic [MW-1:0]         om_r [3][3];
  logic                  odeg_r;
  logic                  out_valid_r;

  assign en        = !t3_v_r || !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bt_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BT_ROW0: bt_r[0] <= cfg_data;
        CFG_BT_ROW1: bt_r[1] <= cfg_data;
        CFG_BT_ROW2: bt_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r      <= 1'b0;
      c2_v_r      <= 1'b0;
      t1_v_r      <= 1'b0;
      t2_v_r      <= 1'b0;
      t3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        c1_v_r <= in_valid;
        c2_v_r <= c1_v_r;
        t1_v_r <= g_st.vld;
        t2_v_r <= t1_v_r;
        t3_v_r <= t2_v_r;
      end
      if (t3_v_r && en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cross product g1 x g2
  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0]    <= in_g1_y * in_g2_z;
      cp_r[1]    <= in_g1_z * in_g2_y;
      cp_r[2]    <= in_g1_z * in_g2_x;
      cp_r[3]    <= in_g1_x * in_g2_z;
      cp_r[4]    <= in_g1_x * in_g2_y;
      cp_r[5]    <= in_g1_y * in_g2_x;
      g1_c1_r[0] <= in_g1_x;
      g1_c1_r[1] <= in_g1_y;
      g1_c1_r[2] <= in_g1_z;
      for (int i = 0; i < 3; i++) begin
        c_r[i]     <= VW'(cp_r[2*i]) - VW'(cp_r[2*i+1]);
        g1_c2_r[i] <= VW'(g1_c1_r[i]);
      end
    end
  end

  o2g_unit #(.STEP_PER(STEP_PER)) u_norm_g (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (c2_v_r),
    .v_i    (g1_c2_r),
    .u_o    (u_g),
    .st_o   (g_st)
  );

  o2g_unit #(.STEP_PER(STEP_PER)) u_norm_c (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (c2_v_r),
    .v_i    (c_r),
    .u_o    (u_c),
    .st_o   (c_st)
  );

  // u2 = u1 x u3, rounded back to Q1.30
  always_comb begin
    logic signed [63:0] r;
    for (int j = 0; j < 3; j++) begin
      r         = rnd_haz(up_r[2*j] - up_r[2*j+1], 30);
      u2_nxt[j] = r[U2W-1:0];
    end
  end

  // BT * U sums, rounded to Q11.20 and forced to zero for a degenerate beat
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [63:0]   r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = AW'(bp_r[i][0][j]) + AW'(bp_r[i][1][j]) + AW'(bp_r[i][2][j]);
        r   = rnd_haz(64'(acc), 22);
        om_nxt[i][j] = deg_t3_r ? '0 : r[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up_r[0]  <= u_g[1] * u_c[2];
      up_r[1]  <= u_g[2] * u_c[1];
      up_r[2]  <= u_g[2] * u_c[0];
      up_r[3]  <= u_g[0] * u_c[2];
      up_r[4]  <= u_g[0] * u_c[1];
      up_r[5]  <= u_g[1] * u_c[0];
      u1_t1_r  <= u_g;
      u3_t1_r  <= u_c;
      deg_t1_r <= g_st.zero || c_st.zero;
      for (int j = 0; j < 3; j++) begin
        ut_r[0][j] <= U2W'(u1_t1_r[j]);
        ut_r[1][j] <= u2_nxt[j];
        ut_r[2][j] <= U2W'(u3_t1_r[j]);
      end
      deg_t2_r <= deg_t1_r;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            bp_r[i][k][j] <= $signed(bt_r[i][BTW*k +: BTW]) * ut_r[k][j];
          end
        end
      end
      deg_t3_r <= deg_t2_r;
    end
    if (t3_v_r && en) begin
      om_r   <= om_nxt;
      odeg_r <= deg_t3_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_m00        = om_r[0][0];
  assign out_m01        = om_r[0][1];
  assign out_m02        = om_r[0][2];
  assign out_m10        = om_r[1][0];
  assign out_m11        = om_r[1][1];
  assign out_m12        = om_r[1][2];
  assign out_m20        = om_r[2][0];
  assign out_m21        = om_r[2][1];
  assign out_m22        = om_r[2][2];
  assign out_degenerate = odeg_r;

  a_unit_align: assert property (@(posedge clk) disable iff (!rst_n)
    g_st.vld == c_st.vld)
    else $error("normaliser valid bits out of step");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_m00 == '0 && out_m01 == '0 && out_m02 == '0 &&
       out_m10 == '0 && out_m11 == '0 && out_m12 == '0 &&
       out_m20 == '0 && out_m21 == '0 && out_m22 == '0))
    else $error("degenerate beat carries a non-zero matrix");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (t3_v_r && out_valid && !out_ready) |-> !in_ready)
    else $error("pipe moved while the last stage was blocked");

endmodule

[rtl/core/o2g_unit.sv]
// ----------------------------------------------------------------------------
// o2g_unit: pipelined vector normaliser
// Magnitudes, leading-one shift, sum of squares, digit-by-digit square root
// and restoring division, giving a Q1.30 unit vector and a zero flag.
// ----------------------------------------------------------------------------
module o2g_unit #(
  parameter int unsigned STEP_PER = o2g_pkg::STEP_PER_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic signed [o2g_pkg::VW-1:0]   v_i [3],
  output logic signed [o2g_pkg::UW-1:0]   u_o [3],
  output o2g_pkg::unit_st_t               st_o
);
  import o2g_pkg::*;

  localparam int unsigned SQ_ST = (SQ_STEPS + STEP_PER - 1) / STEP_PER;
  localparam int unsigned DV_ST = (DV_STEPS + STEP_PER - 1) / STEP_PER;
  localparam int unsigned LAT   = SQ_ST + DV_ST + 7;
  localparam int unsigned PW    = $clog2(VW);
  localparam int unsigned SRW   = RW + 2;
  localparam int unsigned STW   = SRW + 2;

  typedef struct packed {
    logic [SRW-1:0]         rem;
    logic [RW-1:0]          root;
    logic [2*RW-1:0]        s;
    logic [2:0][NW-1:0]     an;
    logic [2:0]             sg;
    logic                   zero;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0]          n;
    logic [2:0][RW-1:0]     r;
    logic [2:0][NW-1:0]     q;
    logic [2:0][NW-1:0]     d;
    logic [2:0]             sg;
    logic                   zero;
  } dv_t;

  logic [LAT-1:0]     vld_r;

  logic [VW-1:0]      a_nxt [3];
  logic [VW-1:0]      m_nxt;
  logic [VW-1:0]      a_a_r [3];
  logic [VW-1:0]      m_a_r;
  logic [2:0]         sg_a_r;

  logic [PW-1:0]      p_nxt;
  logic [VW-1:0]      a_b_r [3];
  logic [PW-1:0]      p_b_r;
  logic [2:0]         sg_b_r;
  logic               zero_b_r;

  logic [NW-1:0]      an_nxt [3];
  logic [NW-1:0]      an_c_r [3];
  logic [2:0]         sg_c_r;
  logic               zero_c_r;

  logic [2*NW-1:0]    sq_d_r [3];
  logic [NW-1:0]      an_d_r [3];
  logic [2:0]         sg_d_r;
  logic               zero_d_r;

  sq_t                sq_nxt [SQ_ST+1];
  sq_t                sq_r   [SQ_ST+1];
  dv_t                dv_nxt [DV_ST+1];
  dv_t                dv_r   [DV_ST+1];
  logic signed [UW-1:0] u_r  [3];
  logic               zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_vld};
    end
  end

  // magnitudes and largest
  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      a_nxt[i] = v_i[i][VW-1] ? VW'(-v_i[i]) : VW'(v_i[i]);
      if (a_nxt[i] > m_nxt) begin
        m_nxt = a_nxt[i];
      end
    end
  end

  // leading one
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < VW; i++) begin
      if (m_a_r[i]) begin
        p_nxt = PW'(i);
      end
    end
  end

  // bring the largest into [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p_b_r > PW'(NW - 1)) begin
        an_nxt[i] = NW'(a_b_r[i] >> (p_b_r - PW'(NW - 1)));
      end else begin
        an_nxt[i] = NW'(a_b_r[i] << (PW'(NW - 1) - p_b_r));
      end
    end
  end

  // square root, two bits of radicand per step
  always_comb begin
    sq_t             w;
    logic [STW-1:0]  tmp;
    logic [STW-1:0]  trial;
    sq_nxt[0].rem  = '0;
    sq_nxt[0].root = '0;
    sq_nxt[0].s    = (2*RW)'(sq_d_r[0]) + (2*RW)'(sq_d_r[1]) + (2*RW)'(sq_d_r[2]);
    for (int i = 0; i < 3; i++) begin
      sq_nxt[0].an[i] = an_d_r[i];
    end
    sq_nxt[0].sg   = sg_d_r;
    sq_nxt[0].zero = zero_d_r;
    for (int st = 1; st <= SQ_ST; st++) begin
      w = sq_r[st-1];
      for (int k = 0; k < STEP_PER; k++) begin
        if ((st - 1) * STEP_PER + k < SQ_STEPS) begin
          tmp   = {w.rem, w.s[2*RW-1 -: 2]};
          w.s   = w.s << 2;
          trial = STW'({w.root, 2'b01});
          if (tmp >= trial) begin
            tmp    = tmp - trial;
            w.root = {w.root[RW-2:0], 1'b1};
          end else begin
            w.root = {w.root[RW-2:0], 1'b0};
          end
          w.rem = tmp[SRW-1:0];
        end
      end
      sq_nxt[st] = w;
    end
  end

  // restoring division a * 2^30 / N, one quotient bit per step
  always_comb begin
    dv_t            w;
    logic [RW:0]    t;
    dv_nxt[0].n = sq_r[SQ_ST].root;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].r[i] = RW'(sq_r[SQ_ST].an[i] >> 1);
      dv_nxt[0].q[i] = '0;
      dv_nxt[0].d[i] = {sq_r[SQ_ST].an[i][0], (NW-1)'(0)};
    end
    dv_nxt[0].sg   = sq_r[SQ_ST].sg;
    dv_nxt[0].zero = sq_r[SQ_ST].zero;
    for (int st = 1; st <= DV_ST; st++) begin
      w = dv_r[st-1];
      for (int k = 0; k < STEP_PER; k++) begin
        if ((st - 1) * STEP_PER + k < DV_STEPS) begin
          for (int i = 0; i < 3; i++) begin
            t      = {w.r[i], w.d[i][NW-1]};
            w.d[i] = w.d[i] << 1;
            if (t >= {1'b0, w.n}) begin
              t      = t - {1'b0, w.n};
              w.q[i] = {w.q[i][NW-2:0], 1'b1};
            end else begin
              w.q[i] = {w.q[i][NW-2:0], 1'b0};
            end
            w.r[i] = t[RW-1:0];
          end
        end
      end
      dv_nxt[st] = w;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_a_r[i]  <= a_nxt[i];
        sg_a_r[i] <= v_i[i][VW-1];
        a_b_r[i]  <= a_a_r[i];
        an_c_r[i] <= an_nxt[i];
        an_d_r[i] <= an_c_r[i];
        sq_d_r[i] <= an_c_r[i] * an_c_r[i];
        if (dv_r[DV_ST].sg[i]) begin
          u_r[i] <= -$signed(UW'(dv_r[DV_ST].q[i]));
        end else begin
          u_r[i] <= $signed(UW'(dv_r[DV_ST].q[i]));
        end
      end
      m_a_r    <= m_nxt;
      p_b_r    <= p_nxt;
      sg_b_r   <= sg_a_r;
      zero_b_r <= (m_a_r == '0);
      sg_c_r   <= sg_b_r;
      zero_c_r <= zero_b_r;
      sg_d_r   <= sg_c_r;
      zero_d_r <= zero_c_r;
      for (int st = 0; st <= SQ_ST; st++) begin
        sq_r[st] <= sq_nxt[st];
      end
      for (int st = 0; st <= DV_ST; st++) begin
        dv_r[st] <= dv_nxt[st];
      end
      zero_r <= dv_r[DV_ST].zero;
    end
  end

  assign u_o        = u_r;
  assign st_o.vld   = vld_r[LAT-1];
  assign st_o.zero  = zero_r;

endmodule

[tb/sv/orientation_from_two_gvectors_tb.sv]
// ----------------------------------------------------------------------------
// orientation_from_two_gvectors_tb: self-checking bench for the orientation block
// Drives pairs of g-vectors through valid/ready under several BT settings. A
// scoreboard works out each BT * U matrix in fixed point and checks it
// field by field. Both sides idle at random, with a long output hold-off.
// ----------------------------------------------------------------------------
module orientation_from_two_gvectors_tb;
  import o2g_pkg::*;

  typedef logic [GW-1:0] comp_t;
  typedef struct packed {
    comp_t [2:0] g1;
    comp_t [2:0] g2;
  } gpair_t;
  typedef struct packed {
    logic [8:0][MW-1:0] m;
    logic               degenerate;
  } matrix_t;
  typedef longint vec3_t[3];

  localparam logic [CIW-1:0] CFG_UNUSED = 2'd3;

  class orientation_scoreboard;
    logic [BTRW-1:0] bt_row[3];
    matrix_t         pending_q[$];
    int              n_errors;
    int              n_checked;
    int              n_degenerate;

    function new();
      foreach (bt_row[i]) bt_row[i] = '0;
      n_errors = 0;
      n_checked = 0;
      n_degenerate = 0;
    endfunction

    function void write_row(logic [CIW-1:0] idx, logic [BTRW-1:0] val);
      if (idx <= CFG_BT_ROW2) bt_row[idx] = val;
    endfunction

    function logic [63:0] magnitude(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    function longint round_half_away(longint x, int n);
      logic [63:0] a;
      a = (magnitude(x) + (64'd1 << (n - 1))) >> n;
      return x < 0 ? -longint'(a) : longint'(a);
    endfunction

    function logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Q1.30 unit vector; returns 0 for a zero vector
    function bit unit_q30(vec3_t v, output vec3_t u);
      logic [63:0] a[3], mx, s, n, q;
      mx = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        a[i] = magnitude(v[i]);
        if (a[i] > mx) mx = a[i];
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 31)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += a[i] * a[i];
      n = root_floor(s);
      for (int i = 0; i < 3; i++) begin
        q = (a[i] << 30) / n;
        u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1;
    endfunction

    function void note_pair(gpair_t p);
      vec3_t   g1, g2, c, u1, u2, u3;
      longint  bt[3], acc;
      matrix_t r;
      for (int i = 0; i < 3; i++) begin
        g1[i] = longint'($signed(p.g1[i]));
        g2[i] = longint'($signed(p.g2[i]));
      end
      c[0] = g1[1] * g2[2] - g1[2] * g2[1];
      c[1] = g1[2] * g2[0] - g1[0] * g2[2];
      c[2] = g1[0] * g2[1] - g1[1] * g2[0];
      r = '0;
      if (!unit_q30(g1, u1) || !unit_q30(c, u3)) begin
        r.degenerate = 1'b1;
      end else begin
        u2[0] = round_half_away(u1[1] * u3[2] - u1[2] * u3[1], 30);
        u2[1] = round_half_away(u1[2] * u3[0] - u1[0] * u3[2], 30);
        u2[2] = round_half_away(u1[0] * u3[1] - u1[1] * u3[0], 30);
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) bt[k] = longint'($signed(bt_row[i][k*BTW +: BTW]));
          for (int j = 0; j < 3; j++) begin
            acc = bt[0] * u1[j] + bt[1] * u2[j] + bt[2] * u3[j];
            r.m[i*3 + j] = MW'(round_half_away(acc, 22));
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_matrix(matrix_t got);
      string   names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
      matrix_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      n_checked++;
      if (exp_r.degenerate) n_degenerate++;
      for (int i = 0; i < 9; i++)
        if (got.m[i] !== exp_r.m[i]) begin
          $error("%s: expected %0d, got %0d", names[i], $signed(exp_r.m[i]),
                 $signed(got.m[i]));
          n_errors++;
        end
      if (got.degenerate !== exp_r.degenerate) begin
        $error("degenerate: expected %0d, got %0d", exp_r.degenerate, got.degenerate);
        n_errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  comp_t in_g1_x, in_g1_y, in_g1_z, in_g2_x, in_g2_y, in_g2_z;
  logic signed [MW-1:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [MW-1:0] out_m20, out_m21, out_m22;
  logic out_degenerate;
  logic [CIW-1:0] cfg_index;
  logic [BTRW-1:0] cfg_data;

  orientation_from_two_gvectors dut (.*);

  orientation_scoreboard sb = new();
  int  burst_left = 1;
  int  n_sent = 0;
  bit  hold_req = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: changing stall pattern plus one long hold-off on request
  initial begin
    int mode, left, hold;
    mode = 0;
    left = 0;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_matrix({out_m22, out_m21, out_m20, out_m12, out_m11, out_m10,
                         out_m02, out_m01, out_m00, out_degenerate});
      if (hold_req && hold == 0) begin
        hold = 400;
        hold_req = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(50, 300);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          2: out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_pair(gpair_t p);
    int gap;
    in_valid <= 1'b1;
    {in_g1_z, in_g1_y, in_g1_x} <= p.g1;
    {in_g2_z, in_g2_y, in_g2_x} <= p.g2;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
    n_sent++;
    if (--burst_left <= 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_bt(logic [CIW-1:0] idx, logic [BTRW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_row(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    return comp_t'($signed(comp_t'($urandom)) >>> $urandom_range(0, 23));
  endfunction

  function automatic gpair_t rand_pair();
    gpair_t p;
    int     k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = ($bits(gpair_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
      4, 5: for (int i = 0; i < 3; i++) begin
        p.g1[i] = rand_comp();
        p.g2[i] = rand_comp();
      end
      6: begin
        k = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) begin
          p.g1[i] = comp_t'($signed(comp_t'($urandom)) >>> 3);
          p.g2[i] = comp_t'(longint'($signed(p.g1[i])) * k);
        end
      end
      7: for (int i = 0; i < 3; i++) begin
        p.g1[i] = $urandom_range(0, 2) == 0 ? '0 : rand_comp();
        p.g2[i] = $urandom_range(0, 2) == 0 ? '0 : rand_comp();
      end
      8: begin
        p.g1 = {rand_comp(), rand_comp(), rand_comp()};
        p.g2 = p.g1;
        p.g2[$urandom_range(0, 2)] += comp_t'(int'($urandom_range(0, 2)) - 1);
      end
      default: for (int i = 0; i < 3; i++) begin
        p.g1[i] = $urandom_range(0, 1) ? comp_t'(24'h7fffff) : comp_t'(24'h800000);
        p.g2[i] = $urandom_range(0, 1) ? comp_t'(24'h7fffff) : rand_comp();
      end
    endcase
    return p;
  endfunction

  function automatic logic [BTRW-1:0] pack_row(int c0, int c1, int c2);
    return {BTW'(c2), BTW'(c1), BTW'(c0)};
  endfunction

  initial begin
    localparam comp_t PMAX = 24'h7fffff;
    localparam comp_t NMIN = 24'h800000;
    gpair_t directed[$];
    directed = '{
      '{g1: '{0, 0, 0},          g2: '{3, 2, 1}},
      '{g1: '{0, 0, 1},          g2: '{0, 0, 0}},
      '{g1: '{3, 2, 1},          g2: '{-6, -4, -2}},
      '{g1: '{0, 0, 1},          g2: '{0, 1, 0}},
      '{g1: '{1, 0, 0},          g2: '{0, 0, 1}},
      '{g1: '{PMAX, PMAX, PMAX}, g2: '{NMIN, NMIN, PMAX}},
      '{g1: '{NMIN, NMIN, NMIN}, g2: '{NMIN, NMIN, NMIN}},
      '{g1: '{NMIN, PMAX, 0},    g2: '{PMAX, 0, NMIN}},
      '{g1: '{PMAX, 0, 0},       g2: '{0, NMIN, 0}},
      '{g1: '{-1, -1, -1},       g2: '{1, -1, 1}},
      '{g1: '{NMIN, 0, 0},       g2: '{NMIN, 0, 1}},
      '{g1: '{24'h100000, 24'h200000, 24'h300000}, g2: '{24'h0fffff, 5, 24'hf00001}}
    };

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BT_ROW0;
    cfg_data  <= '0;
    {in_g1_z, in_g1_y, in_g1_x, in_g2_z, in_g2_y, in_g2_x} <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // BT at reset is zero: matrices come out zero, flag follows
    foreach (directed[i]) send_pair(directed[i]);
    drain();
    write_bt(CFG_BT_ROW0, pack_row(4096, 0, 0));
    write_bt(CFG_BT_ROW1, pack_row(0, 4096, 0));
    write_bt(CFG_BT_ROW2, pack_row(0, 0, 4096));
    foreach (directed[i]) send_pair(directed[i]);

    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        0: for (int r = 0; r < 3; r++) write_bt(cfg_idx_t'(r), BTRW'({$urandom, $urandom}));
        1: for (int r = 0; r < 3; r++)
          write_bt(cfg_idx_t'(r), pack_row(-(1 << 20), -(1 << 20), -(1 << 20)));
        2: for (int r = 0; r < 3; r++)
          write_bt(cfg_idx_t'(r), pack_row((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
        3: begin
          write_bt(CFG_UNUSED, BTRW'({$urandom, $urandom}));
          write_bt(CFG_BT_ROW1, pack_row((1 << 20) - 1, -(1 << 20), 0));
        end
        default: for (int r = 0; r < 3; r++)
          write_bt(cfg_idx_t'(r), BTRW'({$urandom, $urandom}));
      endcase
      for (int n = 0; n < 300; n++) begin
        if (ph == 1 && n == 100) hold_req = 1;
        if (ph == 2 && n == 150) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending_q.size() > 0) @(posedge clk);
        end
        send_pair(rand_pair());
      end
    end

    drain();
    $display("Sent %0d vector pairs under 7 BT settings; %0d results checked, %0d degenerate.",
             n_sent, sb.n_checked, sb.n_degenerate);
    if (sb.n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

[orientation_from_two_gvectors.f]
rtl/core/o2g_pkg.sv
rtl/core/o2g_unit.sv
rtl/core/orientation_from_two_gvectors.sv
tb/sv/orientation_from_two_gvectors_tb.sv
